// ===== design/pse_pkg.sv =====
// ----------------------------------------------------------------------------
// pse_pkg
// Shared types, constants and symbol decode for the postfix stack evaluator.
// ----------------------------------------------------------------------------
package pse_pkg;

  localparam int unsigned WORD_W      = 32;
  localparam int unsigned STACK_DEPTH = 128;
  localparam int unsigned ADDR_W      = $clog2(STACK_DEPTH);
  localparam int unsigned CNT_W       = $clog2(STACK_DEPTH + 1);
  localparam int unsigned STEP_W      = $clog2(WORD_W);
  localparam int unsigned SYM_W       = 8;
  localparam int unsigned OUT_TDATA_W = 40;
  localparam int unsigned OUT_PAD_W   = OUT_TDATA_W - WORD_W - 3;

  // Item kinds carried on the input tuser bit
  localparam logic OP_SYMBOL = 1'b0;
  localparam logic OP_FINISH = 1'b1;

  // ASCII codes
  localparam logic [SYM_W-1:0] SYM_ZERO  = 8'h30;
  localparam logic [SYM_W-1:0] SYM_NINE  = 8'h39;
  localparam logic [SYM_W-1:0] SYM_PLUS  = 8'h2B;
  localparam logic [SYM_W-1:0] SYM_MINUS = 8'h2D;
  localparam logic [SYM_W-1:0] SYM_TIMES = 8'h2A;
  localparam logic [SYM_W-1:0] SYM_SLASH = 8'h2F;

  typedef logic [WORD_W-1:0] word_t;

  typedef enum logic [1:0] {
    ALU_ADD,
    ALU_SUB,
    ALU_MUL,
    ALU_DIV
  } alu_op_e;

  typedef enum logic [1:0] {
    A_IDLE,
    A_DIV,
    A_FIX,
    A_DONE
  } alu_state_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_POP_R,
    S_WAIT_R,
    S_POP_L,
    S_WAIT_L,
    S_START,
    S_CALC,
    S_FIN_POP,
    S_FIN_WAIT,
    S_FIN_OUT
  } seq_state_e;

  typedef struct packed {
    logic    start;
    alu_op_e op;
  } alu_req_t;

  typedef struct packed {
    logic done;
    logic div0;
  } alu_rsp_t;

  typedef struct packed {
    logic div0;
    logic over;
    logic under;
  } err_flags_t;

  function automatic logic is_digit(input logic [SYM_W-1:0] sym);
    return (sym >= SYM_ZERO) && (sym <= SYM_NINE);
  endfunction

  function automatic logic is_arith(input logic [SYM_W-1:0] sym);
    return (sym == SYM_PLUS) || (sym == SYM_MINUS) ||
           (sym == SYM_TIMES) || (sym == SYM_SLASH);
  endfunction

  function automatic alu_op_e alu_op_of(input logic [SYM_W-1:0] sym);
    alu_op_e op;
    op = ALU_ADD;
    if (sym == SYM_MINUS) op = ALU_SUB;
    if (sym == SYM_TIMES) op = ALU_MUL;
    if (sym == SYM_SLASH) op = ALU_DIV;
    return op;
  endfunction

endpackage

// ===== design/pse_stack_ram.sv =====
// ----------------------------------------------------------------------------
// pse_stack_ram
// Single-write, single-read memory with registered read data.
// ----------------------------------------------------------------------------
module pse_stack_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 128,
  parameter int unsigned AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== design/pse_alu.sv =====
// ----------------------------------------------------------------------------
// pse_alu
// Shared arithmetic unit: registered add, subtract and multiply, signed
// divide by a restoring loop, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module pse_alu
  import pse_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  alu_req_t req_i,
  input  word_t    a_i,
  input  word_t    b_i,
  output alu_rsp_t rsp_o,
  output word_t    result_o
);

  alu_state_e        state_q, state_d;
  logic [STEP_W-1:0] step_q, step_d;
  word_t             quo_q, quo_d;
  word_t             rem_q, rem_d;
  word_t             ub_q, ub_d;
  logic              neg_q, neg_d;
  word_t             res_q, res_d;
  logic              div0_q, div0_d;

  word_t           abs_a, abs_b;
  logic [WORD_W:0] rem_sh, diff;

  assign abs_a  = a_i[WORD_W-1] ? (word_t'(0) - a_i) : a_i;
  assign abs_b  = b_i[WORD_W-1] ? (word_t'(0) - b_i) : b_i;
  assign rem_sh = {rem_q, quo_q[WORD_W-1]};
  assign diff   = rem_sh - {1'b0, ub_q};

  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    quo_d   = quo_q;
    rem_d   = rem_q;
    ub_d    = ub_q;
    neg_d   = neg_q;
    res_d   = res_q;
    div0_d  = div0_q;
    unique case (state_q)
      A_IDLE: begin
        if (req_i.start) begin
          div0_d  = 1'b0;
          state_d = A_DONE;
          unique case (req_i.op)
            ALU_ADD: res_d = a_i + b_i;
            ALU_SUB: res_d = a_i - b_i;
            ALU_MUL: res_d = word_t'(a_i * b_i);
            ALU_DIV: begin
              if (b_i == '0) begin
                res_d  = '0;
                div0_d = 1'b1;
              end else begin
                quo_d   = abs_a;
                rem_d   = '0;
                ub_d    = abs_b;
                neg_d   = a_i[WORD_W-1] ^ b_i[WORD_W-1];
                step_d  = '0;
                state_d = A_DIV;
              end
            end
            default: res_d = '0;
          endcase
        end
      end
      A_DIV: begin
        // restore unless the trial subtract stays non-negative
        if (!diff[WORD_W]) begin
          rem_d = diff[WORD_W-1:0];
          quo_d = {quo_q[WORD_W-2:0], 1'b1};
        end else begin
          rem_d = rem_sh[WORD_W-1:0];
          quo_d = {quo_q[WORD_W-2:0], 1'b0};
        end
        step_d = step_q + 1'b1;
        if (step_q == STEP_W'(WORD_W - 1)) begin
          state_d = A_FIX;
        end
      end
      A_FIX: begin
        res_d   = neg_q ? (word_t'(0) - quo_q) : quo_q;
        state_d = A_DONE;
      end
      A_DONE: state_d = A_IDLE;
      default: state_d = A_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= A_IDLE;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q  <= quo_d;
    rem_q  <= rem_d;
    ub_q   <= ub_d;
    neg_q  <= neg_d;
    res_q  <= res_d;
    div0_q <= div0_d;
  end

  assign rsp_o.done = (state_q == A_DONE);
  assign rsp_o.div0 = div0_q;
  assign result_o   = res_q;

endmodule

// ===== design/postfix_stack_evaluator_core.sv =====
// ----------------------------------------------------------------------------
// postfix_stack_evaluator_core
// Steps per item: a digit is pushed at accept; any other symbol pops its right
//   then left operand, skipping the wait state when the stack is empty; an
//   operator then runs in pse_alu (divide by its 32-step restoring loop) and
//   its result is pushed. A finish pops and sends the top once the output is free.
// Throughput: one item at a time; s_axis_tready is high only when idle.
// Reset: clears count, flags, sequencer and output valid; memory is not reset.
// ----------------------------------------------------------------------------
module postfix_stack_evaluator_core
  import pse_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // input stream
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [SYM_W-1:0]       s_axis_tdata,  // [7:0] symbol
  input  logic                   s_axis_tuser,  // [0] op (0 symbol, 1 finish)
  // result stream
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // [31:0] value, [32] underflow_seen, [33] overflow_seen,
  // [34] divide_by_zero_seen, [39:35] zero
  output logic [OUT_TDATA_W-1:0] m_axis_tdata
);

  seq_state_e       state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  err_flags_t       flags_q, flags_d;
  logic [SYM_W-1:0] sym_q, sym_d;
  word_t            rhs_q, rhs_d;   // right operand, also the finish value
  word_t            lhs_q, lhs_d;
  logic [OUT_TDATA_W-1:0] out_q, out_d;
  logic             out_valid_q, out_valid_d;

  // Stack memory port
  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  word_t             ram_wdata;
  logic [ADDR_W-1:0] ram_raddr;
  word_t             ram_rdata;

  // Shared unit handshake
  alu_req_t alu_req;
  alu_rsp_t alu_rsp;
  word_t    alu_result;

  logic [CNT_W-1:0] cnt_dec;
  logic             stack_empty;
  logic             stack_full;
  seq_state_e       after_lhs;

  assign cnt_dec     = cnt_q - 1'b1;
  assign stack_empty = (cnt_q == '0);
  assign stack_full  = (cnt_q == CNT_W'(STACK_DEPTH));
  // Operators go on to the shared unit; any other symbol just drops its operands
  assign after_lhs   = is_arith(sym_q) ? S_START : S_IDLE;

  assign s_axis_tready = (state_q == S_IDLE);

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    flags_d     = flags_q;
    sym_d       = sym_q;
    rhs_d       = rhs_q;
    lhs_d       = lhs_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !m_axis_tready;
    ram_we      = 1'b0;
    ram_waddr   = cnt_q[ADDR_W-1:0];
    ram_wdata   = '0;
    ram_raddr   = cnt_dec[ADDR_W-1:0];
    alu_req     = '{start: 1'b0, op: alu_op_of(sym_q)};

    unique case (state_q)
      S_IDLE: begin
        if (s_axis_tvalid) begin
          sym_d = s_axis_tdata;
          if (s_axis_tuser == OP_FINISH) begin
            state_d = S_FIN_POP;
          end else if (is_digit(s_axis_tdata)) begin
            // push the digit value now; drop it and flag when full
            if (!stack_full) begin
              ram_we    = 1'b1;
              ram_wdata = word_t'(s_axis_tdata - SYM_ZERO);
              cnt_d     = cnt_q + 1'b1;
            end else begin
              flags_d.over = 1'b1;
            end
          end else begin
            state_d = S_POP_R;
          end
        end
      end
      S_POP_R: begin
        if (stack_empty) begin
          rhs_d         = '1;
          flags_d.under = 1'b1;
          state_d       = S_POP_L;
        end else begin
          cnt_d   = cnt_dec;
          state_d = S_WAIT_R;
        end
      end
      S_WAIT_R: begin
        rhs_d   = ram_rdata;
        state_d = S_POP_L;
      end
      S_POP_L: begin
        if (stack_empty) begin
          lhs_d         = '1;
          flags_d.under = 1'b1;
          state_d       = after_lhs;
        end else begin
          cnt_d   = cnt_dec;
          state_d = S_WAIT_L;
        end
      end
      S_WAIT_L: begin
        lhs_d   = ram_rdata;
        state_d = after_lhs;
      end
      S_START: begin
        alu_req.start = 1'b1;
        state_d       = S_CALC;
      end
      S_CALC: begin
        // hold until the shared unit finishes, then push its result or flag overflow when full
        if (alu_rsp.done) begin
          if (alu_rsp.div0) begin
            flags_d.div0 = 1'b1;
          end
          if (!stack_full) begin
            ram_we    = 1'b1;
            ram_wdata = alu_result;
            cnt_d     = cnt_q + 1'b1;
          end else begin
            flags_d.over = 1'b1;
          end
          state_d = S_IDLE;
        end
      end
      S_FIN_POP: begin
        if (stack_empty) begin
          rhs_d         = '1;
          flags_d.under = 1'b1;
          state_d       = S_FIN_OUT;
        end else begin
          cnt_d   = cnt_dec;
          state_d = S_FIN_WAIT;
        end
      end
      S_FIN_WAIT: begin
        rhs_d   = ram_rdata;
        state_d = S_FIN_OUT;
      end
      S_FIN_OUT: begin
        // wait for a free output register, then report and clear the stack and flags
        if (!out_valid_q || m_axis_tready) begin
          out_d       = {OUT_PAD_W'(0), flags_q.div0, flags_q.over, flags_q.under, rhs_q};
          out_valid_d = 1'b1;
          cnt_d       = '0;
          flags_d     = '0;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      flags_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      flags_q     <= flags_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sym_q <= sym_d;
    rhs_q <= rhs_d;
    lhs_q <= lhs_d;
    out_q <= out_d;
  end

  pse_stack_ram #(
    .Width (WORD_W),
    .Depth (STACK_DEPTH),
    .AddrW (ADDR_W)
  ) u_stack_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  pse_alu u_alu (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .req_i    (alu_req),
    .a_i      (lhs_q),
    .b_i      (rhs_q),
    .rsp_o    (alu_rsp),
    .result_o (alu_result)
  );

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_q;

endmodule
